@@ rtl/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants for the square attack count tracker: board
// geometry, counter store addressing and the sequencer state encoding.
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int SQUARES = 64;
    localparam int SIDES   = 2;
    localparam int SQ_W    = $clog2(SQUARES);
    localparam int SIDE_W  = $clog2(SIDES);
    localparam int ADDR_W  = SQ_W + SIDE_W;

    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SQUARES-1:0] map_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_port_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/square_attack_count_tracker.sv @@
// ----------------------------------------------------------------------------
// square_attack_count_tracker
// Per-side, per-square saturating attack counters with a live occupancy map
// per side. Each item walks the set bits of its mask, one counter update each.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, mode, side, attack_mask | into block
//   out     | out_valid, out_ready, side_map           | out of block
//
// An item steps through ST_RUN, one read-modify-write per set bit of its mask
// through the single counter store port pair and shared update unit, with the
// read of one bit overlapped with the write of the last, then through ST_FINISH
// to out_valid; no new item is accepted until the block is back in ST_IDLE.
// in_ready rises together with out_valid, even if the result is not yet taken.
// A stalled result delays the final load into the output register and holds the block in ST_FINISH.
// Reset clears all counters and maps at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module square_attack_count_tracker #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic                side,
    input  logic [63:0]         attack_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         side_map
);
    import sact_pkg::*;

    state_t    state_reg, state_next;
    map_t      mask_reg, mask_next;
    logic      mode_reg, side_reg;
    map_t      maps_reg [SIDES];
    map_t      maps_next [SIDES];
    logic      pend_vld_reg, pend_vld_next;
    sq_t       pend_sq_reg;
    logic      out_vld_reg, out_vld_next;
    map_t      out_map_reg;

    map_t      low_bit;
    sq_t       low_sq;
    logic      accept, issue, load_out;

    mem_port_t              rd_port, wr_port;
    logic [COUNT_WIDTH-1:0] rd_count, new_count;
    logic                   occupied;

    // lowest set bit of the remaining mask
    assign low_bit = mask_reg & (~mask_reg + map_t'(1));

    always_comb
    begin
        low_sq = '0;
        for (int i = 0; i < SQUARES; i++)
        begin
            if (low_bit[i])
            begin
                low_sq = low_sq | sq_t'(i);
            end
        end
    end

    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_RUN) && (mask_reg != '0);
    assign load_out = (state_reg == ST_FINISH) && (!out_vld_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_RUN:    in_ready = 1'b0;
            ST_FINISH: in_ready = 1'b0;
            default:   in_ready = 1'b0;
        endcase
    end

    assign rd_port.en   = issue;
    assign rd_port.addr = {side_reg, low_sq};
    assign wr_port.en   = pend_vld_reg;
    assign wr_port.addr = {side_reg, pend_sq_reg};

    sact_count_mem #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_port (rd_port),
        .wr_port (wr_port),
        .wr_data (new_count),
        .rd_data (rd_count)
    );

    sact_count_alu #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alu (
        .remove    (mode_reg),
        .count     (rd_count),
        .count_new (new_count),
        .occupied  (occupied)
    );

    always_comb
    begin
        mask_next     = mask_reg;
        pend_vld_next = issue;
        maps_next     = maps_reg;
        out_vld_next  = out_vld_reg;
        if (accept)
        begin
            mask_next = attack_mask;
        end
        else if (issue)
        begin
            mask_next = mask_reg & ~low_bit;
        end
        // write back the occupancy of the square just updated
        if (pend_vld_reg)
        begin
            maps_next[side_reg][pend_sq_reg] = occupied;
        end
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int s = 0; s < SIDES; s++)
            begin
                maps_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            maps_reg     <= maps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (accept)
        begin
            mode_reg <= mode;
            side_reg <= side;
        end
        if (issue)
        begin
            pend_sq_reg <= low_sq;
        end
        if (load_out)
        begin
            out_map_reg <= maps_reg[side_reg];
        end
    end

    assign out_valid = out_vld_reg;
    assign side_map  = out_map_reg;

endmodule

@@ rtl/sact_count_mem.sv @@
// ----------------------------------------------------------------------------
// sact_count_mem
// Counter store: one entry per side and square, one write and one registered
// read port. Per-entry valid bits make never-written entries read as zero.
// ----------------------------------------------------------------------------
module sact_count_mem #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sact_pkg::mem_port_t    rd_port,
    input  sact_pkg::mem_port_t    wr_port,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    output logic [COUNT_WIDTH-1:0] rd_data
);
    import sact_pkg::*;

    localparam int DEPTH = SIDES * SQUARES;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_port.en)
        begin
            mem[wr_port.addr] <= wr_data;
        end
        if (rd_port.en)
        begin
            rd_data_reg <= mem[rd_port.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_port.en)
            begin
                vld_reg[wr_port.addr] <= 1'b1;
            end
            if (rd_port.en)
            begin
                rd_vld_reg <= vld_reg[rd_port.addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/sact_count_alu.sv @@
// ----------------------------------------------------------------------------
// sact_count_alu
// Shared counter update unit: saturating increment or floored decrement of
// one counter, with the resulting occupancy bit for the side map.
// ----------------------------------------------------------------------------
module sact_count_alu #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                   remove,
    input  logic [COUNT_WIDTH-1:0] count,
    output logic [COUNT_WIDTH-1:0] count_new,
    output logic                   occupied
);
    import sact_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] ONE       = COUNT_WIDTH'(1);

    always_comb
    begin
        count_new = count;
        if (!remove)
        begin
            if (count != COUNT_MAX)
            begin
                count_new = count + ONE;
            end
        end
        else if (count != '0)
        begin
            count_new = count - ONE;
        end
    end

    assign occupied = (count_new != '0);

endmodule
